// ===== hdl/hti_pkg.sv =====
// Shared types and constants for the Huffman code-tree decoder.
// No dependencies; every other file of the block imports this package.
package hti_pkg;

  // Sizing of the node store and of the code walk.
  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 32;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int CNT_W        = $clog2(NODE_COUNT + 1);
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int SUM_W        = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  // Fixed field widths.
  localparam int CODE_W    = 32;
  localparam int CLEN_W    = 6;
  localparam int SYM_W     = 8;
  localparam int BITS_W    = 32;
  localparam int BYTE_BITS = 8;
  localparam int BYTE_LAST = BYTE_BITS - 1;
  localparam int BIDX_W    = $clog2(BYTE_BITS + 1);
  localparam int BSEL_W    = $clog2(BYTE_BITS);

  // Depth of the command queue between front and engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Action codes as they arrive on the input channel.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  // Internal operation after classification.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_DECODE,
    OP_NOP
  } op_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  data;
  } cmd_t;

  // One node of the code tree; a child index of zero means no child.
  typedef struct packed {
    logic [NODE_W-1:0] child0;
    logic [NODE_W-1:0] child1;
    logic [SYM_W-1:0]  sym;
  } node_t;

  localparam node_t NODE_EMPTY = '0;

endpackage

// ===== hdl/hti_front.sv =====
// Front stage of the Huffman code-tree decoder: classifies input items.
// Depends on hti_pkg for the command and operation types.
module hti_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [hti_pkg::CODE_W-1:0] code_bits,
  input  logic [hti_pkg::CLEN_W-1:0] code_length,
  input  logic [hti_pkg::SYM_W-1:0] symbol_in,
  input  logic [hti_pkg::SYM_W-1:0] data_byte,
  output logic                      q_valid,
  input  logic                      q_ready,
  output hti_pkg::cmd_t             q_cmd
);
  import hti_pkg::*;

  // A transaction moves straight into the queue when it has room.
  assign q_valid  = in_valid;
  assign in_ready = q_ready;

  // Map the action code to an operation; the unused code does nothing.
  // Long codes are cut to the longest supported length.
  always_comb begin
    q_cmd.code = code_bits;
    q_cmd.sym  = symbol_in;
    q_cmd.data = data_byte;
    unique case (action)
      ACT_CLEAR:  q_cmd.op = OP_CLEAR;
      ACT_ADD:    q_cmd.op = OP_ADD;
      ACT_DECODE: q_cmd.op = OP_DECODE;
      default:    q_cmd.op = OP_NOP;
    endcase
    if (code_length > MAX_CODE_LEN) begin
      q_cmd.len = LEN_W'(MAX_CODE_LEN);
    end else begin
      q_cmd.len = LEN_W'(code_length);
    end
  end

endmodule

// ===== hdl/hti_cmd_fifo.sv =====
// Short command queue that decouples the front stage from the engine.
// Depends on hti_pkg for the command type and the queue depth.
module hti_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  hti_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output hti_pkg::cmd_t rd_cmd
);
  import hti_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Slot storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== hdl/hti_engine.sv =====
// Back stage of the Huffman code-tree decoder: node store, tree build and bit walk.
// Depends on hti_pkg for node, command and operation types.
module hti_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  hti_pkg::cmd_t             q_cmd,
  input  logic [hti_pkg::BITS_W-1:0] total_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hti_pkg::SYM_W-1:0] symbol_out,
  output logic                      symbol_valid,
  output logic                      status,
  output logic                      last
);
  import hti_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AFOLLOW,
    S_AWAIT,
    S_ACHECK,
    S_ABUILD,
    S_DSTEP,
    S_RESP
  } state_t;

  state_t            state;
  cmd_t              cmd;
  node_t             root;
  logic [CNT_W-1:0]  nodes_used;
  logic [NODE_W-1:0] walk_node;
  logic [BITS_W-1:0] bits_left;

  // Add walk registers.
  logic [NODE_W-1:0] cur_node;
  node_t             cur_entry;
  logic [LEN_W-1:0]  k;

  // Decode walk registers: the node reached by the last issued bit.
  logic [NODE_W-1:0] arr_node;
  logic              arr_root;
  logic              arr_check;
  logic [BIDX_W-1:0] bit_idx;
  logic [SYM_W-1:0]  pend_sym;
  logic              pend_valid;
  logic              resp_status;

  // Node store for every node but the root, which lives in flip-flops.
  node_t             mem [NODE_COUNT];
  node_t             rdata;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  node_t             wr_data;

  logic              out_space;
  logic [LEN_W-1:0]  k_dec;
  logic [CODE_W-1:0] code_sh;
  logic              code_bit;
  logic [NODE_W-1:0] add_child;
  logic              pool_full;
  logic [NODE_W-1:0] new_idx;
  node_t             build_entry;
  node_t             arr_entry;
  logic              arr_leaf;
  node_t             dec_entry;
  logic              dec_bit;
  logic              dec_issue;
  logic [NODE_W-1:0] dec_next;
  logic              dec_stall;
  logic              push;
  logic [SYM_W-1:0]  push_sym;
  logic              push_valid;
  logic              push_status;
  logic              push_last;

  assign q_ready   = (state == S_IDLE);
  assign out_space = !out_valid || out_ready;

  // Code bit for the current depth of an add, first bit at the top.
  assign k_dec    = LEN_W'(k - 1'b1);
  assign code_sh  = cmd.code >> k_dec;
  assign code_bit = code_sh[0];
  assign add_child = code_bit ? cur_entry.child1 : cur_entry.child0;
  assign pool_full = (SUM_W'(nodes_used) + SUM_W'(k)) > SUM_W'(NODE_COUNT);
  assign new_idx   = nodes_used[NODE_W-1:0];

  // Entry written back while building: the symbol at the end, else a new child link.
  always_comb begin
    build_entry = cur_entry;
    if (k == '0) begin
      build_entry.sym = cmd.sym;
    end else if (code_bit) begin
      build_entry.child1 = new_idx;
    end else begin
      build_entry.child0 = new_idx;
    end
  end

  // Decode: check the node reached by the last issued bit, then pick the next child.
  assign arr_entry = arr_root ? root : rdata;
  assign arr_leaf  = arr_check && (arr_entry.child0 == '0) && (arr_entry.child1 == '0);
  assign dec_entry = arr_leaf ? root : arr_entry;
  assign dec_bit   = cmd.data[BSEL_W'(BYTE_LAST - bit_idx)];
  assign dec_issue = (bit_idx < BIDX_W'(BYTE_BITS)) && (bits_left != '0);
  assign dec_next  = dec_bit ? dec_entry.child1 : dec_entry.child0;
  assign dec_stall = arr_leaf && pend_valid && !out_space;

  // Node store port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = walk_node;
    wr_en   = 1'b0;
    wr_addr = cur_node;
    wr_data = build_entry;
    unique case (state)
      S_IDLE: begin
        rd_en   = q_valid && (q_cmd.op == OP_DECODE);
        rd_addr = walk_node;
      end
      S_AFOLLOW: begin
        rd_en   = (k != '0) && (add_child != '0);
        rd_addr = add_child;
      end
      S_ABUILD: begin
        wr_en = (cur_node != '0);
      end
      S_DSTEP: begin
        rd_en   = dec_issue && !dec_stall;
        rd_addr = dec_next;
      end
      S_AWAIT, S_ACHECK, S_RESP: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Result push: a symbol from the walk, or the closing transaction of an action.
  always_comb begin
    push        = 1'b0;
    push_sym    = pend_sym;
    push_valid  = 1'b1;
    push_status = 1'b0;
    push_last   = 1'b0;
    if (state == S_RESP) begin
      push        = out_space;
      push_sym    = pend_valid ? pend_sym : '0;
      push_valid  = pend_valid;
      push_status = resp_status;
      push_last   = 1'b1;
    end else if (state == S_DSTEP) begin
      push = arr_leaf && pend_valid && out_space;
    end
  end

  // Sequencer with tree state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root       <= NODE_EMPTY;
      nodes_used <= CNT_W'(1);
      walk_node  <= '0;
      bits_left  <= '0;
      pend_valid <= 1'b0;
      arr_check  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid    <= 1'b1;
        symbol_out   <= push_sym;
        symbol_valid <= push_valid;
        status       <= push_status;
        last         <= push_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd         <= q_cmd;
            pend_valid  <= 1'b0;
            resp_status <= 1'b0;
            unique case (q_cmd.op)
              OP_CLEAR: begin
                root       <= NODE_EMPTY;
                nodes_used <= CNT_W'(1);
                walk_node  <= '0;
                bits_left  <= total_bits;
                state      <= S_RESP;
              end
              OP_ADD: begin
                cur_node  <= '0;
                cur_entry <= root;
                k         <= q_cmd.len;
                state     <= S_AFOLLOW;
              end
              OP_DECODE: begin
                arr_node  <= walk_node;
                arr_root  <= (walk_node == '0);
                arr_check <= 1'b0;
                bit_idx   <= '0;
                state     <= S_DSTEP;
              end
              OP_NOP: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_AFOLLOW: begin
          if ((k == '0) || (add_child == '0)) begin
            state <= S_ACHECK;
          end else begin
            cur_node <= add_child;
            k        <= k_dec;
            state    <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          cur_entry <= rdata;
          state     <= S_AFOLLOW;
        end
        S_ACHECK: begin
          if (pool_full) begin
            resp_status <= 1'b1;
            state       <= S_RESP;
          end else begin
            state <= S_ABUILD;
          end
        end
        S_ABUILD: begin
          if (cur_node == '0) begin
            root <= build_entry;
          end
          if (k == '0) begin
            state <= S_RESP;
          end else begin
            cur_node   <= new_idx;
            cur_entry  <= NODE_EMPTY;
            nodes_used <= CNT_W'(nodes_used + 1'b1);
            k          <= k_dec;
          end
        end
        S_DSTEP: begin
          if (!dec_stall) begin
            if (arr_check) begin
              walk_node <= arr_leaf ? '0 : arr_node;
            end
            if (arr_leaf) begin
              pend_sym   <= arr_entry.sym;
              pend_valid <= 1'b1;
            end
            if (dec_issue) begin
              arr_node  <= dec_next;
              arr_root  <= (dec_next == '0);
              arr_check <= 1'b1;
              bit_idx   <= BIDX_W'(bit_idx + 1'b1);
              bits_left <= BITS_W'(bits_left - 1'b1);
            end else begin
              arr_check <= 1'b0;
              state     <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_space) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  // A new node is only built while the pool still has room.
  a_pool_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_ABUILD && k != '0) |-> (nodes_used < CNT_W'(NODE_COUNT)))
    else $error("node built with the pool full");

  // The walk never points past the allocated nodes.
  a_walk_in_pool: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(walk_node) < nodes_used))
    else $error("walk node outside the allocated pool");

  // A result without a symbol is always the closing one of its action.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !symbol_valid) |-> last)
    else $error("empty result not marked last");

  // A leaf reached by an unstalled step leaves a symbol pending.
  a_leaf_pends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTEP && arr_leaf && !dec_stall) |=> pend_valid)
    else $error("leaf symbol lost");
`endif

endmodule

// ===== hdl/huffman_trie_decoder.sv =====
// Top level of the Huffman code-tree decoder: configuration register and wiring.
// Depends on hti_pkg, hti_front, hti_cmd_fifo and hti_engine.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     action, code_bits, code_length,
//                                              symbol_in, data_byte
// out       output     out_valid / out_ready   symbol_out, symbol_valid, status, last
// cfg       input      cfg_valid / cfg_ready   cfg_data (total_bits)
//
// A decode byte primes the node-store read, walks its coded bits with dependent
// node-store reads, checks the last node and gives its result. Clear and the unused
// action go straight to their result; an add reads one node per existing tree level
// and builds each new node. Output stalls hold the engine; cfg_ready is always high.
// Reset empties the tree, zeroes total_bits and bits_left; no clearing pass is run.
// A two-entry command queue lets input transactions enter while the engine waits.
module huffman_trie_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 action,
  input  logic [hti_pkg::CODE_W-1:0] code_bits,
  input  logic [hti_pkg::CLEN_W-1:0] code_length,
  input  logic [hti_pkg::SYM_W-1:0]  symbol_in,
  input  logic [hti_pkg::SYM_W-1:0]  data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hti_pkg::SYM_W-1:0]  symbol_out,
  output logic                       symbol_valid,
  output logic                       status,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hti_pkg::BITS_W-1:0] cfg_data
);
  import hti_pkg::*;

  logic              fq_valid;
  logic              fq_ready;
  cmd_t              fq_cmd;
  logic              qe_valid;
  logic              qe_ready;
  cmd_t              qe_cmd;
  logic [BITS_W-1:0] total_bits;

  // Configuration register, written by a cfg transaction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      total_bits <= cfg_data;
    end
  end

  // Classification of incoming transactions.
  hti_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .code_bits   (code_bits),
    .code_length (code_length),
    .symbol_in   (symbol_in),
    .data_byte   (data_byte),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .q_cmd       (fq_cmd)
  );

  // Queue between the front and the engine.
  hti_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qe_valid),
    .rd_ready (qe_ready),
    .rd_cmd   (qe_cmd)
  );

  // Tree store, add walk and decode walk.
  hti_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qe_valid),
    .q_ready      (qe_ready),
    .q_cmd        (qe_cmd),
    .total_bits   (total_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_out   (symbol_out),
    .symbol_valid (symbol_valid),
    .status       (status),
    .last         (last)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for huffman_trie_decoder: directed table, then random code-tree sessions.
// Depends on hti_pkg and the decoder RTL; results are checked against an in-bench tree model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hti_pkg::*;

  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam logic [31:0] FILL_STRIDE  = 32'h0800_0000;
  localparam int          RANDOM_ITEMS = 250;
  localparam int          CYCLE_LIMIT  = 600_000;
  localparam int          DIR_ROWS     = 32;

  // One command on the input channel.
  typedef struct packed {
    logic [1:0]        act;
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  data;
  } trie_cmd_t;

  // One result on the output channel.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             valid;
    logic             status;
    logic             last;
  } sym_result_t;

  // A code word of a generated prefix code.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
  } code_word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // A directed row; config rows carry the register value in code.
  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        act;
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  data;
    logic [4:0]        reps;
    logic              typed;
    logic              tstat;
  } row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_TRICKLE} rx_mode_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          action = ACT_CLEAR;
  logic [CODE_W-1:0]   code_bits = '0;
  logic [CLEN_W-1:0]   code_length = '0;
  logic [SYM_W-1:0]    symbol_in = '0;
  logic [SYM_W-1:0]    data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SYM_W-1:0]    symbol_out;
  logic                symbol_valid;
  logic                status;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BITS_W-1:0]   cfg_data = '0;

  // Tree model: child indexes per node (zero means none), symbols and walk state.
  int unsigned         branch [NODE_COUNT][2];
  logic [SYM_W-1:0]    node_symbol [NODE_COUNT];
  int unsigned         nodes_taken;
  int unsigned         walk_pos;
  logic [BITS_W-1:0]   bits_remaining;
  logic [BITS_W-1:0]   total_bits_q;

  sym_result_t         step_out [$];
  sym_result_t         expected_symbols [$];
  row_t                dir_rows [DIR_ROWS];

  int                  cycle_count = 0;
  int                  error_count = 0;
  int                  commands_sent = 0;
  int                  random_items = 0;
  int                  results_seen = 0;
  int                  symbols_seen = 0;
  int                  pool_full_adds = 0;
  int                  cfg_writes = 0;
  int                  burst_left = 0;
  bit                  in_random_phase = 1'b0;
  rx_mode_t            rx_mode = RX_OPEN;
  int                  rx_left = 0;

  huffman_trie_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .symbol_in    (symbol_in),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_out   (symbol_out),
    .symbol_valid (symbol_valid),
    .status       (status),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Work out the results of one command and update the tree model.
  function automatic void predict_symbols(input trie_cmd_t c);
    int unsigned k;
    int unsigned node;
    int unsigned nxt;
    int          i;
    bit          have;
    bit          full;
    sym_result_t held;
    step_out.delete();
    have = 1'b0;
    full = 1'b0;
    held = '0;
    if (c.act == ACT_CLEAR) begin
      branch[0][0] = 0;
      branch[0][1] = 0;
      node_symbol[0] = '0;
      nodes_taken = 1;
      walk_pos = 0;
      bits_remaining = total_bits_q;
    end else if (c.act == ACT_ADD) begin
      k = (c.len > MAX_CODE_LEN) ? MAX_CODE_LEN : c.len;
      node = 0;
      // Follow the part of the code that already exists.
      while (k > 0 && branch[node][c.code[k-1]] != 0) begin
        node = branch[node][c.code[k-1]];
        k--;
      end
      if (nodes_taken + k > NODE_COUNT) begin
        full = 1'b1;
      end else begin
        while (k > 0) begin
          branch[nodes_taken][0] = 0;
          branch[nodes_taken][1] = 0;
          node_symbol[nodes_taken] = '0;
          branch[node][c.code[k-1]] = nodes_taken;
          node = nodes_taken;
          nodes_taken++;
          k--;
        end
        node_symbol[node] = c.sym;
      end
    end else if (c.act == ACT_DECODE) begin
      i = BYTE_LAST;
      // A missing child lands on the root, which may itself be a leaf.
      while (i >= 0 && bits_remaining != 0) begin
        nxt = branch[walk_pos][c.data[i]];
        if (branch[nxt][0] == 0 && branch[nxt][1] == 0) begin
          if (have) step_out.push_back(held);
          held = {node_symbol[nxt], 1'b1, 1'b0, 1'b0};
          have = 1'b1;
          nxt = 0;
        end
        walk_pos = nxt;
        bits_remaining = bits_remaining - 1;
        i--;
      end
    end
    if (have) begin
      held.last = 1'b1;
      step_out.push_back(held);
    end else begin
      step_out.push_back({8'h00, 1'b0, full, 1'b1});
    end
  endfunction

  function automatic trie_cmd_t random_cmd(input logic [1:0] act);
    trie_cmd_t c;
    c.act  = act;
    c.code = $urandom();
    c.len  = CLEN_W'($urandom_range(0, 63));
    c.sym  = SYM_W'($urandom());
    c.data = SYM_W'($urandom());
    return c;
  endfunction

  // Drive one command in bursts with random gaps, then record its expected results.
  task automatic send_cmd(input trie_cmd_t c, input bit typed, input bit tstat);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= c.act;
    code_bits   <= c.code;
    code_length <= c.len;
    symbol_in   <= c.sym;
    data_byte   <= c.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_symbols(c);
    if (c.act == ACT_ADD && step_out[0].status) pool_full_adds++;
    if (typed) begin
      expected_symbols.push_back({8'h00, 1'b0, tstat, 1'b1});
    end else begin
      foreach (step_out[n]) expected_symbols.push_back(step_out[n]);
    end
    commands_sent++;
    if (in_random_phase && c.act != ACT_UNUSED) random_items++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0:       send_cmd(random_cmd(ACT_ADD), 1'b0, 1'b0);
      1:       send_cmd(random_cmd(ACT_UNUSED), 1'b0, 1'b0);
      default: send_cmd(random_cmd(ACT_DECODE), 1'b0, 1'b0);
    endcase
  endtask

  // Let every outstanding result drain, then give the engine time to settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_total_bits(input logic [BITS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    total_bits_q = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Output stall pattern: open, toggling, random or trickling stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_mode <= RX_OPEN;
        1:       rx_mode <= RX_TOGGLE;
        2:       rx_mode <= RX_RANDOM;
        default: rx_mode <= RX_TRICKLE;
      endcase
      rx_left <= $urandom_range(4, 48);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_TOGGLE: out_ready <= !out_ready;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= (rx_left % 8 == 0);
    endcase
  end

  // Compare each result transaction with the oldest expected one.
  always @(posedge clk) begin : check_results
    sym_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (symbol_valid === 1'b1) symbols_seen++;
      if (expected_symbols.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected result: sym %02h valid %0b status %0b last %0b",
                   symbol_out, symbol_valid, status, last);
      end else begin
        want = expected_symbols.pop_front();
        if (symbol_out !== want.sym || symbol_valid !== want.valid ||
            status !== want.status || last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display({"Mismatch at cycle %0d: expected sym %02h valid %0b status %0b ",
                      "last %0b, got sym %02h valid %0b status %0b last %0b"},
                     cycle_count, want.sym, want.valid, want.status, want.last,
                     symbol_out, symbol_valid, status, last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             expected_symbols.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    row_t        rw;
    trie_cmd_t   cmd;
    code_word_t  lf;
    code_word_t  leaves [$];
    code_word_t  order [$];
    bit          stream_bits [$];
    logic [31:0] rep_code;
    int          rep;
    int          session;
    int          pick;
    int          idx;
    int          n_leaves;
    int          nbytes;
    int          j;

    // Directed rows: kind, action, code, length, symbol, data, repeats, typed, status.
    dir_rows = '{
      // No bits loaded yet after reset, and the unused action with all-ones fields.
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hFF, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF, 8'hFF, 5'd1,  1'b1, 1'b0},
      {ROW_CFG,  ACT_CLEAR,  32'hFFFF_FFFF, 6'd0,  8'h00, 8'h00, 5'd1,  1'b0, 1'b0},
      // Empty tree: the root is a leaf, then an empty code puts a symbol there.
      {ROW_ITEM, ACT_CLEAR,  32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hA5, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0000, 6'd0,  8'h77, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b0, 1'b0},
      // Prefix code 0, 10, 110, 111; garbage above the used bits must be ignored.
      {ROW_ITEM, ACT_ADD,    32'h0000_0000, 6'd1,  8'h11, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0002, 6'd2,  8'h22, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'hFFFF_FFFE, 6'd3,  8'h33, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0007, 6'd3,  8'h44, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h5B, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h80, 5'd1,  1'b0, 1'b0},
      // Repeated code, then an over-long code that saturates to the maximum length.
      {ROW_ITEM, ACT_ADD,    32'h0000_0002, 6'd2,  8'h55, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'hFFFF_FFFF, 6'd63, 8'hAA, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hFF, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h40, 5'd1,  1'b0, 1'b0},
      // Bit budget runs out in the middle of a byte.
      {ROW_CFG,  ACT_CLEAR,  32'h0000_000D, 6'd0,  8'h00, 8'h00, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_CLEAR,  32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0000, 6'd1,  8'hC3, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0001, 6'd1,  8'h3C, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h5A, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'hFF, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b1, 1'b0},
      // Fill the node pool with long codes until an add is refused.
      {ROW_CFG,  ACT_CLEAR,  32'hFFFF_FFFF, 6'd0,  8'h00, 8'h00, 5'd1,  1'b0, 1'b0},
      {ROW_ITEM, ACT_CLEAR,  32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h0000_0000, 6'd32, 8'h01, 8'h00, 5'd18, 1'b0, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'hFFFF_FFFF, 6'd32, 8'h99, 8'h00, 5'd1,  1'b1, 1'b1},
      {ROW_ITEM, ACT_ADD,    32'h0000_0000, 6'd32, 8'h5A, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_DECODE, 32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd4,  1'b0, 1'b0},
      {ROW_ITEM, ACT_CLEAR,  32'h0000_0000, 6'd0,  8'h00, 8'h00, 5'd1,  1'b1, 1'b0},
      {ROW_ITEM, ACT_ADD,    32'h8000_0000, 6'd32, 8'hE1, 8'h00, 5'd1,  1'b1, 1'b0}
    };

    // Model state after reset.
    foreach (branch[n]) begin
      branch[n][0] = 0;
      branch[n][1] = 0;
      node_symbol[n] = '0;
    end
    nodes_taken = 1;
    walk_pos = 0;
    bits_remaining = '0;
    total_bits_q = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    foreach (dir_rows[r]) begin
      rw = dir_rows[r];
      if (rw.kind == ROW_CFG) begin
        drain_results();
        write_total_bits(rw.code);
      end else begin
        for (rep = 0; rep < rw.reps; rep++) begin
          rep_code = rw.code + rep * FILL_STRIDE;
          cmd = {rw.act, rep_code, rw.len, rw.sym, rw.data};
          send_cmd(cmd, rw.typed, rw.tstat);
        end
      end
    end

    // Random sessions: build a prefix code, then decode streams made from it.
    in_random_phase = 1'b1;
    session = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2 || session == 0) begin
        drain_results();
        case ($urandom_range(0, 4))
          0:       write_total_bits('0);
          1:       write_total_bits($urandom_range(1, 64));
          2:       write_total_bits($urandom());
          default: write_total_bits('1);
        endcase
      end
      if (pick == 2) begin
        // Pool stress: many long random codes, most of them refused once full.
        send_cmd(random_cmd(ACT_CLEAR), 1'b0, 1'b0);
        repeat (24) begin
          cmd = random_cmd(ACT_ADD);
          cmd.len = CLEN_W'($urandom_range(20, 40));
          send_cmd(cmd, 1'b0, 1'b0);
        end
        repeat (6) send_cmd(random_cmd(ACT_DECODE), 1'b0, 1'b0);
      end else begin
        if ($urandom_range(0, 5) != 0) send_cmd(random_cmd(ACT_CLEAR), 1'b0, 1'b0);
        // Split random leaves until the code has the wanted size.
        n_leaves = $urandom_range(2, 12);
        leaves.delete();
        leaves.push_back({32'd0, 6'd0});
        while (leaves.size() < n_leaves) begin
          idx = $urandom_range(0, leaves.size() - 1);
          lf = leaves[idx];
          if (lf.len < 9) begin
            leaves[idx] = {lf.code << 1, lf.len + 6'd1};
            leaves.push_back({(lf.code << 1) | 32'd1, lf.len + 6'd1});
          end
        end
        // Add the code words in random order with random upper bits.
        order = leaves;
        while (order.size() > 0) begin
          idx = $urandom_range(0, order.size() - 1);
          lf = order[idx];
          order.delete(idx);
          if ($urandom_range(0, 9) == 0) send_noise();
          cmd = random_cmd(ACT_ADD);
          cmd.code = lf.code | (cmd.code << lf.len);
          cmd.len = lf.len;
          send_cmd(cmd, 1'b0, 1'b0);
        end
        // Pack a stream of random code words into bytes, MSB first.
        nbytes = $urandom_range(2, 10);
        stream_bits.delete();
        while (stream_bits.size() < nbytes * BYTE_BITS) begin
          lf = leaves[$urandom_range(0, leaves.size() - 1)];
          for (j = lf.len; j > 0; j--) stream_bits.push_back(lf.code[j-1]);
        end
        repeat (nbytes) begin
          if ($urandom_range(0, 11) == 0) send_noise();
          cmd = random_cmd(ACT_DECODE);
          for (j = 0; j < BYTE_BITS; j++)
            cmd.data = {cmd.data[SYM_W-2:0], stream_bits.pop_front()};
          send_cmd(cmd, 1'b0, 1'b0);
        end
      end
      session++;
    end

    drain_results();
    $display("Ran %0d commands (%0d random, %0d sessions) and %0d register writes.",
             commands_sent, random_items, session, cfg_writes);
    $display("Saw %0d results, %0d decoded symbols, %0d refused adds; %0d mismatches.",
             results_seen, symbols_seen, pool_full_adds, error_count);
    if (error_count == 0 && expected_symbols.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hti_pkg.sv
hdl/hti_front.sv
hdl/hti_cmd_fifo.sv
hdl/hti_engine.sv
hdl/huffman_trie_decoder.sv
sim/tb.sv
